// ===== hw/rtl/aps_pkg.sv =====
`default_nettype none

package aps_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int WI_W             = $clog2(WORDS_PER_SECTOR);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_DATA   = 2'd2;

  localparam logic [1:0] CFG_WRITE_WAIT   = 2'd0;
  localparam logic [1:0] CFG_READY_WAIT   = 2'd1;
  localparam logic [1:0] CFG_REQUEST_WAIT = 2'd2;
  localparam logic [1:0] CFG_RESET_HOLD   = 2'd3;

  localparam logic [15:0] WAIT_LIMIT_RST = 16'd1000;
  localparam logic [15:0] HOLD_TICKS_RST = 16'd5;
  localparam logic [15:0] WAIT_MAX       = 16'hffff;

  localparam logic [2:0] RC_OK        = 3'd0;
  localparam logic [2:0] RC_INVALID   = 3'd1;
  localparam logic [2:0] RC_TIMEOUT   = 3'd2;
  localparam logic [2:0] RC_READ_ERR  = 3'd3;
  localparam logic [2:0] RC_WRITE_ERR = 3'd4;

  localparam logic [3:0] PORT_NONE     = 4'd0;
  localparam logic [3:0] PORT_SECT_CNT = 4'd2;
  localparam logic [3:0] PORT_SECT_NUM = 4'd3;
  localparam logic [3:0] PORT_CYL_LO   = 4'd4;
  localparam logic [3:0] PORT_CYL_HI   = 4'd5;
  localparam logic [3:0] PORT_DRV_HD   = 4'd6;
  localparam logic [3:0] PORT_CMD      = 4'd7;
  localparam logic [3:0] PORT_CTRL     = 4'd8;

  localparam int ST_BSY  = 7;
  localparam int ST_DRDY = 6;
  localparam int ST_DRQ  = 3;
  localparam int ST_ERR  = 0;

  localparam logic [7:0]  DRVHD_BASE = 8'ha0;
  localparam logic [3:0]  HEAD_MASK  = 4'h0f;
  localparam logic [7:0]  CMD_READ   = 8'h20;
  localparam logic [7:0]  CMD_WRITE  = 8'h30;
  localparam logic [15:0] CTRL_SRST  = 16'h0004;
  localparam logic [15:0] CTRL_CLEAR = 16'h0000;

  localparam logic [2:0] STEP_CMD = 3'd4;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_SAMPLE,
    KIND_DATA
  } kind_t;

  typedef enum logic [1:0] {
    OP_REG_WR   = 2'd0,
    OP_DATA     = 2'd1,
    OP_ACK      = 2'd2,
    OP_COMPLETE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEL,
    PH_READY,
    PH_REGS,
    PH_DRQ,
    PH_DATA,
    PH_HOLD,
    PH_FINISH
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic        is_write;
    logic        drive_select;
    logic [3:0]  head;
    logic [7:0]  sector_number;
    logic [15:0] cylinder;
    logic [7:0]  sector_count;
    logic [7:0]  status_byte;
    logic [15:0] data_word;
  } item_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  reg_port;
    logic [15:0] value;
    logic [2:0]  result_code;
    logic        last;
  } result_t;

  function automatic result_t mk_res(op_t op, logic [3:0] port, logic [15:0] value,
                                     logic [2:0] code);
    result_t r;
    r.op          = op;
    r.reg_port    = port;
    r.value       = value;
    r.result_code = code;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ata_pio_sector_sequencer.sv =====
// An accepted item is queued, taken by the sequencer, and its result registered in the
// output slot. Throughput: one item per cycle unless the output stalls; an item that
// yields two results (last word of a sector, end of a reset hold) holds the sequencer
// until its second result has left the pending slot.
// A four-entry queue between the input classifier and the sequencer absorbs stalls.
// Reset (rst_n low, synchronous): sequencer idle, queue empty, no result pending,
// wait limits back to 1000 samples and the reset hold to 5 ticks.
`default_nettype none

module ata_pio_sector_sequencer
  import aps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic        in_is_write,
  input  wire logic        in_drive_select,
  input  wire logic [3:0]  in_head,
  input  wire logic [7:0]  in_sector_number,
  input  wire logic [15:0] in_cylinder,
  input  wire logic [7:0]  in_sector_count,
  input  wire logic [7:0]  in_status_byte,
  input  wire logic [15:0] in_data_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_op,
  output logic [3:0]       out_reg_port,
  output logic [15:0]      out_value,
  output logic [2:0]       out_result_code,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t out_res;

  aps_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_is_write      (in_is_write),
    .in_drive_select  (in_drive_select),
    .in_head          (in_head),
    .in_sector_number (in_sector_number),
    .in_cylinder      (in_cylinder),
    .in_sector_count  (in_sector_count),
    .in_status_byte   (in_status_byte),
    .in_data_word     (in_data_word),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  aps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_op          = out_res.op;
  assign out_reg_port    = out_res.reg_port;
  assign out_value       = out_res.value;
  assign out_result_code = out_res.result_code;
  assign out_last        = out_res.last;

endmodule

`default_nettype wire

// ===== hw/rtl/aps_front.sv =====
`default_nettype none

module aps_front
  import aps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic        in_is_write,
  input  wire logic        in_drive_select,
  input  wire logic [3:0]  in_head,
  input  wire logic [7:0]  in_sector_number,
  input  wire logic [15:0] in_cylinder,
  input  wire logic [7:0]  in_sector_count,
  input  wire logic [7:0]  in_status_byte,
  input  wire logic [15:0] in_data_word,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  item_t           item;
  logic            keep;
  logic            push;

  // unknown request codes are taken and dropped here, they never reach the sequencer
  always_comb begin
    item               = '0;
    keep               = 1'b1;
    item.is_write      = in_is_write;
    item.drive_select  = in_drive_select;
    item.head          = in_head;
    item.sector_number = in_sector_number;
    item.cylinder      = in_cylinder;
    item.sector_count  = in_sector_count;
    item.status_byte   = in_status_byte;
    item.data_word     = in_data_word;
    case (in_req_type)
      REQ_START:  item.kind = KIND_START;
      REQ_SAMPLE: item.kind = KIND_SAMPLE;
      REQ_DATA:   item.kind = KIND_DATA;
      default: begin
        item.kind = KIND_SAMPLE;
        keep      = 1'b0;
      end
    endcase
  end

  assign in_ready = (count_r != (Q_AW+1)'(Q_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aps_back.sv =====
`default_nettype none

module aps_back
  import aps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output result_t          out_res
);

  logic [15:0]     write_wait_limit_r, ready_wait_limit_r;
  logic [15:0]     request_wait_limit_r, reset_hold_ticks_r;

  phase_t          phase_r, phase_nxt;
  logic [15:0]     wait_count_r, wait_count_nxt;
  logic [2:0]      write_step_r, write_step_nxt;
  logic            latched_write_r, latched_write_nxt;
  logic            latched_drive_r, latched_drive_nxt;
  logic [3:0]      latched_head_r, latched_head_nxt;
  logic [7:0]      latched_sector_r, latched_sector_nxt;
  logic [15:0]     latched_cylinder_r, latched_cylinder_nxt;
  logic [7:0]      latched_count_r, latched_count_nxt;
  logic [7:0]      sectors_left_r, sectors_left_nxt;
  logic [WI_W-1:0] word_index_r, word_index_nxt;

  result_t         out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  result_t         pend_r, pend_nxt;
  logic            pend_valid_r, pend_valid_nxt;

  result_t         res0, res1;
  logic [1:0]      n_res;
  logic            slot_free;
  logic [15:0]     wc_inc;
  logic [15:0]     lim;
  logic            expired;
  logic [7:0]      st;
  logic [2:0]      ws;
  logic [7:0]      sl_dec;
  logic [7:0]      reg_val;
  logic [3:0]      reg_port;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_wait_limit_r   <= WAIT_LIMIT_RST;
      ready_wait_limit_r   <= WAIT_LIMIT_RST;
      request_wait_limit_r <= WAIT_LIMIT_RST;
      reset_hold_ticks_r   <= HOLD_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WRITE_WAIT:   write_wait_limit_r   <= cfg_data;
        CFG_READY_WAIT:   ready_wait_limit_r   <= cfg_data;
        CFG_REQUEST_WAIT: request_wait_limit_r <= cfg_data;
        CFG_RESET_HOLD:   reset_hold_ticks_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // an item is taken only when both of its results have room to land
  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = q_valid && !pend_valid_r && slot_free;

  assign st     = q_item.status_byte;
  assign wc_inc = (wait_count_r == WAIT_MAX) ? wait_count_r : wait_count_r + 16'd1;
  assign ws     = (write_step_r > STEP_CMD) ? STEP_CMD : write_step_r;
  assign sl_dec = sectors_left_r - 8'd1;

  always_comb begin
    case (phase_r)
      PH_SEL, PH_REGS: lim = write_wait_limit_r;
      PH_READY:        lim = ready_wait_limit_r;
      PH_DRQ:          lim = request_wait_limit_r;
      default:         lim = reset_hold_ticks_r;
    endcase
  end
  // a zero limit expires on the first failing sample, as the compare is on the bumped count
  assign expired = (wc_inc >= lim);

  always_comb begin
    case (ws)
      3'd0: begin
        reg_val  = latched_count_r;
        reg_port = PORT_SECT_CNT;
      end
      3'd1: begin
        reg_val  = latched_sector_r;
        reg_port = PORT_SECT_NUM;
      end
      3'd2: begin
        reg_val  = latched_cylinder_r[7:0];
        reg_port = PORT_CYL_LO;
      end
      3'd3: begin
        reg_val  = latched_cylinder_r[15:8];
        reg_port = PORT_CYL_HI;
      end
      default: begin
        reg_val  = latched_write_r ? CMD_WRITE : CMD_READ;
        reg_port = PORT_CMD;
      end
    endcase
  end

  always_comb begin
    phase_nxt            = phase_r;
    wait_count_nxt       = wait_count_r;
    write_step_nxt       = write_step_r;
    latched_write_nxt    = latched_write_r;
    latched_drive_nxt    = latched_drive_r;
    latched_head_nxt     = latched_head_r;
    latched_sector_nxt   = latched_sector_r;
    latched_cylinder_nxt = latched_cylinder_r;
    latched_count_nxt    = latched_count_r;
    sectors_left_nxt     = sectors_left_r;
    word_index_nxt       = word_index_r;
    res0                 = '0;
    res1                 = '0;
    n_res                = 2'd0;

    if (q_pop) begin
      case (q_item.kind)
        KIND_START: begin
          if (phase_r == PH_IDLE) begin
            if (q_item.sector_count == 8'd0) begin
              res0  = mk_res(OP_COMPLETE, PORT_NONE, 16'd0, RC_INVALID);
              n_res = 2'd1;
            end else begin
              latched_write_nxt    = q_item.is_write;
              latched_drive_nxt    = q_item.drive_select;
              latched_head_nxt     = q_item.head;
              latched_sector_nxt   = q_item.sector_number;
              latched_cylinder_nxt = q_item.cylinder;
              latched_count_nxt    = q_item.sector_count;
              sectors_left_nxt     = q_item.sector_count;
              word_index_nxt       = '0;
              write_step_nxt       = 3'd0;
              wait_count_nxt       = 16'd0;
              phase_nxt            = PH_SEL;
            end
          end
        end
        KIND_DATA: begin
          if (phase_r == PH_DATA) begin
            res0           = mk_res(OP_DATA, PORT_NONE, q_item.data_word, RC_OK);
            n_res          = 2'd1;
            word_index_nxt = word_index_r + 1'b1;
            if (word_index_r == WI_W'(WORDS_PER_SECTOR - 1)) begin
              word_index_nxt   = '0;
              sectors_left_nxt = sl_dec;
              res1             = mk_res(OP_ACK, PORT_NONE, {8'd0, sl_dec}, RC_OK);
              n_res            = 2'd2;
              wait_count_nxt   = 16'd0;
              phase_nxt        = (sl_dec != 8'd0) ? PH_DRQ : PH_FINISH;
            end
          end
        end
        default: begin
          case (phase_r)
            PH_SEL, PH_REGS: begin
              if (!st[ST_BSY] && !st[ST_DRQ]) begin
                n_res          = 2'd1;
                wait_count_nxt = 16'd0;
                if (phase_r == PH_SEL) begin
                  res0 = mk_res(OP_REG_WR, PORT_DRV_HD,
                                {8'd0, DRVHD_BASE | {3'b000, latched_drive_r,
                                                     latched_head_r & HEAD_MASK}},
                                RC_OK);
                  phase_nxt = PH_READY;
                end else begin
                  res0 = mk_res(OP_REG_WR, reg_port, {8'd0, reg_val}, RC_OK);
                  if (ws == STEP_CMD) begin
                    write_step_nxt = ws;
                    phase_nxt      = PH_DRQ;
                  end else begin
                    write_step_nxt = ws + 3'd1;
                  end
                end
              end else begin
                wait_count_nxt = wc_inc;
                if (expired) begin
                  res0           = mk_res(OP_REG_WR, PORT_CTRL, CTRL_SRST, RC_OK);
                  n_res          = 2'd1;
                  wait_count_nxt = 16'd0;
                  phase_nxt      = PH_HOLD;
                end
              end
            end
            PH_READY, PH_DRQ: begin
              if (!st[ST_BSY] && st[ST_ERR]) begin
                res0      = mk_res(OP_COMPLETE, PORT_NONE, 16'd0,
                                   latched_write_r ? RC_WRITE_ERR : RC_READ_ERR);
                n_res     = 2'd1;
                phase_nxt = PH_IDLE;
              end else if (!st[ST_BSY] &&
                           ((phase_r == PH_READY) ? st[ST_DRDY] : st[ST_DRQ])) begin
                wait_count_nxt = 16'd0;
                if (phase_r == PH_READY) begin
                  write_step_nxt = 3'd0;
                  phase_nxt      = PH_REGS;
                end else begin
                  word_index_nxt = '0;
                  phase_nxt      = PH_DATA;
                end
              end else begin
                wait_count_nxt = wc_inc;
                if (expired) begin
                  res0      = mk_res(OP_COMPLETE, PORT_NONE, 16'd0, RC_TIMEOUT);
                  n_res     = 2'd1;
                  phase_nxt = PH_IDLE;
                end
              end
            end
            PH_HOLD: begin
              wait_count_nxt = wc_inc;
              if (expired) begin
                res0      = mk_res(OP_REG_WR, PORT_CTRL, CTRL_CLEAR, RC_OK);
                res1      = mk_res(OP_COMPLETE, PORT_NONE, 16'd0, RC_TIMEOUT);
                n_res     = 2'd2;
                phase_nxt = PH_IDLE;
              end
            end
            PH_FINISH: begin
              res0      = mk_res(OP_COMPLETE, PORT_NONE, 16'd0, RC_OK);
              n_res     = 2'd1;
              phase_nxt = PH_IDLE;
            end
            default: ;
          endcase
        end
      endcase
    end

    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (slot_free) begin
      if (pend_valid_r) begin
        out_nxt        = pend_r;
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = 1'b0;
      end else if (n_res != 2'd0) begin
        out_nxt        = res0;
        out_valid_nxt  = 1'b1;
        pend_nxt       = res1;
        pend_valid_nxt = (n_res == 2'd2);
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_IDLE;
      wait_count_r       <= '0;
      write_step_r       <= '0;
      latched_write_r    <= 1'b0;
      latched_drive_r    <= 1'b0;
      latched_head_r     <= '0;
      latched_sector_r   <= '0;
      latched_cylinder_r <= '0;
      latched_count_r    <= '0;
      sectors_left_r     <= '0;
      word_index_r       <= '0;
      out_valid_r        <= 1'b0;
      pend_valid_r       <= 1'b0;
    end else begin
      phase_r            <= phase_nxt;
      wait_count_r       <= wait_count_nxt;
      write_step_r       <= write_step_nxt;
      latched_write_r    <= latched_write_nxt;
      latched_drive_r    <= latched_drive_nxt;
      latched_head_r     <= latched_head_nxt;
      latched_sector_r   <= latched_sector_nxt;
      latched_cylinder_r <= latched_cylinder_nxt;
      latched_count_r    <= latched_count_nxt;
      sectors_left_r     <= sectors_left_nxt;
      word_index_r       <= word_index_nxt;
      out_valid_r        <= out_valid_nxt;
      pend_valid_r       <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/aps_checker.sv =====
`default_nettype none

module aps_checker
  import aps_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_op,
  input wire logic [3:0]  out_reg_port,
  input wire logic [2:0]  out_result_code,
  input wire logic        out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a complete always closes the item that caused it
  a_complete_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op == OP_COMPLETE |-> out_last)
    else $error("complete without last");

  // an acknowledge is always the final result of its data word
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op == OP_ACK |-> out_last && out_reg_port == PORT_NONE)
    else $error("acknowledge malformed");

  a_code_only_on_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op != OP_COMPLETE |-> out_result_code == RC_OK)
    else $error("result code outside complete");

  // a data word that is not last must be followed by its sector acknowledge
  a_word_then_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_op == OP_DATA && !out_last |=>
      out_valid && out_op == OP_ACK)
    else $error("missing acknowledge after last word");

endmodule

bind ata_pio_sector_sequencer aps_checker u_aps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_op          (out_op),
  .out_reg_port    (out_reg_port),
  .out_result_code (out_result_code),
  .out_last        (out_last)
);

`default_nettype wire
